>>> hw/rtl/cfp_pkg.sv
// Shared types, constants and helper functions for the command frame parser.
// Used by cfp_parser, cfp_emitter and command_frame_parser; depends on nothing.
package cfp_pkg;

    // Frame marker bytes.
    localparam logic [7:0] HDR_BYTE  = 8'h55;
    localparam logic [7:0] TAIL_BYTE = 8'hBB;
    localparam logic [7:0] CMD_BYTE  = 8'hBC;
    localparam logic [7:0] ONE_BYTE  = 8'h01;

    // Frame bytes 1 to 6 are stored; byte 7 is taken straight from the input.
    localparam int unsigned STORED_BYTES = 6;
    localparam int unsigned CNT_W        = $clog2(STORED_BYTES + 1);

    // The status reply has eight bytes.
    localparam int unsigned REPLY_LEN = 8;
    localparam int unsigned REPLY_W   = $clog2(REPLY_LEN);

    // Result kind codes as they appear on the output.
    localparam logic [1:0] KIND_OPEN  = 2'd0;
    localparam logic [1:0] KIND_RESET = 2'd1;
    localparam logic [1:0] KIND_REPLY = 2'd2;

    // Motor mode codes.
    localparam logic [1:0] MODE_OPEN  = 2'd1;
    localparam logic [1:0] MODE_RESET = 2'd2;

    // Default device identifier after reset.
    localparam logic [7:0] DEVICE_ID_RESET = 8'h00;

    // Action chosen for an accepted frame.
    typedef enum logic [1:0] {
        JOB_OPEN,
        JOB_RESET,
        JOB_REPLY
    } cfp_job_kind_t;

    // Request from the parser to the emitter.
    typedef struct packed {
        logic          valid;
        cfp_job_kind_t kind;
        logic [7:0]    id;
        logic          m1;
        logic          m2;
    } cfp_job_t;

    // One byte of the status reply: 55 BC id 01 m1 m2 sum BB.
    function automatic logic [7:0] reply_at(input logic [REPLY_W-1:0] idx,
                                            input logic [7:0] id,
                                            input logic m1,
                                            input logic m2);
        logic [7:0] sum;
        logic [7:0] res;
        sum = id + ONE_BYTE + {7'd0, m1} + {7'd0, m2};
        unique case (idx)
            3'd0:    res = HDR_BYTE;
            3'd1:    res = CMD_BYTE;
            3'd2:    res = id;
            3'd3:    res = ONE_BYTE;
            3'd4:    res = {7'd0, m1};
            3'd5:    res = {7'd0, m2};
            3'd6:    res = sum;
            default: res = TAIL_BYTE;
        endcase
        return res;
    endfunction

endpackage

>>> hw/rtl/command_frame_parser.sv
// Top level of the command frame parser: input register, device id register,
// and instances of cfp_parser and cfp_emitter. Depends on cfp_pkg.
//
//  Channel   Signals                                  Handshake
//  --------  ---------------------------------------  ---------------------------
//  input     in_valid, in_stall, rx_byte, motor_mode  taken when valid & !stall
//  output    out_valid, out_stall, kind, reply_byte,  taken when valid & !stall
//            last
//  config    cfg_valid, cfg_ready, device_id          written when valid & ready
//
//  One received byte per cycle while in_stall is low. A byte is judged while it
//  waits in the input register and the emitter is free; its first result is then
//  written to the result register. A status reply occupies the result register for
//  its eight bytes, and the next byte waits in the input register while it runs.
//  Reset clears the hunt state, the counters and the valid flags; device_id is 0.
//  A stalled output holds its request and backs up into in_stall.
module command_frame_parser #(
    parameter logic [7:0] DeviceIdReset = cfp_pkg::DEVICE_ID_RESET
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic [1:0] motor_mode,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] kind,
    output logic [7:0] reply_byte,
    output logic       last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] device_id
);
    import cfp_pkg::*;

    logic       in_valid_reg;
    logic [7:0] rx_reg;
    logic [1:0] mode_reg;
    logic [7:0] device_id_reg;
    logic       in_accept;
    logic       step;
    logic       job_ready;
    cfp_job_t   job;

    // Handshake: the input register drains into the parser when the emitter is free.
    assign step      = in_valid_reg && job_ready;
    assign in_stall  = in_valid_reg && !job_ready;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // Input valid flag and configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            device_id_reg <= DeviceIdReset;
        end
        else
        begin
            if (in_accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (step)
            begin
                in_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                device_id_reg <= device_id;
            end
        end
    end

    // Input payload register.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            rx_reg   <= rx_byte;
            mode_reg <= motor_mode;
        end
    end

    cfp_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .rx_byte    (rx_reg),
        .motor_mode (mode_reg),
        .device_id  (device_id_reg),
        .job        (job)
    );

    cfp_emitter u_emitter (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (step),
        .job        (job),
        .job_ready  (job_ready),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .reply_byte (reply_byte),
        .last       (last)
    );

    // The input side only stalls while a byte is waiting in the input register.
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg)
        else $error("input stalled with empty input register");

    // A waiting byte that is stalled is still there next cycle.
    a_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !job_ready) |=> in_valid_reg)
        else $error("stalled input byte lost");

    // A request from the parser that is handed over reaches the result register.
    a_job_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (job.valid && in_valid_reg && job_ready) |=> out_valid)
        else $error("request did not reach the result register");

endmodule

>>> hw/rtl/cfp_parser.sv
// Header hunt, frame byte collection and frame judgment.
// Depends on cfp_pkg for marker bytes, counts and the request type.
module cfp_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        rx_byte,
    input  logic [1:0]        motor_mode,
    input  logic [7:0]        device_id,
    output cfp_pkg::cfp_job_t job
);
    import cfp_pkg::*;

    logic             header_seen_reg;
    logic             header_seen_next;
    logic [CNT_W-1:0] byte_count_reg;
    logic [CNT_W-1:0] byte_count_next;
    logic [7:0]       frame_reg [STORED_BYTES];

    logic             frame_done;
    logic [7:0]       body_sum;
    logic             frame_ok;

    // The current byte completes the frame when six bytes are already stored.
    assign frame_done = header_seen_reg && (byte_count_reg == CNT_W'(STORED_BYTES));

    // Checksum over frame bytes 2 to 5, modulo 256.
    assign body_sum = frame_reg[1] + frame_reg[2] + frame_reg[3] + frame_reg[4];

    assign frame_ok = (rx_byte == TAIL_BYTE) && (frame_reg[5] == body_sum)
                   && (frame_reg[0] == CMD_BYTE) && (frame_reg[1] == device_id);

    // Action selection; the first matching test wins.
    always_comb
    begin
        job.valid = 1'b0;
        job.kind  = JOB_OPEN;
        job.id    = device_id;
        job.m1    = (motor_mode == MODE_OPEN);
        job.m2    = (motor_mode == MODE_RESET);
        if (frame_done && frame_ok)
        begin
            priority if (frame_reg[3] == ONE_BYTE)
            begin
                job.valid = 1'b1;
                job.kind  = JOB_OPEN;
            end
            else if (frame_reg[4] == ONE_BYTE)
            begin
                job.valid = 1'b1;
                job.kind  = JOB_RESET;
            end
            else if (frame_reg[2] == ONE_BYTE)
            begin
                job.valid = 1'b1;
                job.kind  = JOB_REPLY;
            end
        end
    end

    // Next state of the hunt and the byte counter.
    always_comb
    begin
        header_seen_next = header_seen_reg;
        byte_count_next  = byte_count_reg;
        if (!header_seen_reg)
        begin
            if (rx_byte == HDR_BYTE)
            begin
                header_seen_next = 1'b1;
                byte_count_next  = '0;
            end
        end
        else if (frame_done)
        begin
            header_seen_next = 1'b0;
            byte_count_next  = '0;
        end
        else
        begin
            byte_count_next = byte_count_reg + 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_seen_reg <= 1'b0;
            byte_count_reg  <= '0;
        end
        else if (step)
        begin
            header_seen_reg <= header_seen_next;
            byte_count_reg  <= byte_count_next;
        end
    end

    // Frame byte store; every entry is written before the frame reads it.
    always_ff @(posedge clk)
    begin
        if (step && header_seen_reg && !frame_done)
        begin
            frame_reg[byte_count_reg] <= rx_byte;
        end
    end

    // The counter never passes the number of stored bytes.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= CNT_W'(STORED_BYTES))
        else $error("byte counter out of range");

    // While hunting, no bytes are counted.
    a_hunt_count: assert property (@(posedge clk) disable iff (!rst_n)
        !header_seen_reg |-> byte_count_reg == '0)
        else $error("byte counter not clear while hunting");

    // A request is only raised on the byte that completes a frame.
    a_job_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        job.valid |-> frame_done)
        else $error("request outside frame completion");

endmodule

>>> hw/rtl/cfp_emitter.sv
// Result register and status reply sequencer.
// Depends on cfp_pkg for kind codes, the request type and reply_at().
module cfp_emitter (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  cfp_pkg::cfp_job_t job,
    output logic              job_ready,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        kind,
    output logic [7:0]        reply_byte,
    output logic              last
);
    import cfp_pkg::*;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [1:0]         kind_reg;
    logic [1:0]         kind_next;
    logic [7:0]         byte_reg;
    logic [7:0]         byte_next;
    logic               last_reg;
    logic               last_next;
    logic               seq_active_reg;
    logic               seq_active_next;
    logic [REPLY_W-1:0] seq_idx_reg;
    logic [REPLY_W-1:0] seq_idx_next;
    logic [7:0]         id_reg;
    logic               m1_reg;
    logic               m2_reg;
    logic               out_free;
    logic               load_job;

    // The result register can be refilled when empty or taken this cycle.
    assign out_free  = !out_valid_reg || !out_stall;
    assign job_ready = out_free && !seq_active_reg;
    assign load_job  = take && job.valid;

    // Next result: reply bytes in flight first, then a new request.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        kind_next       = kind_reg;
        byte_next       = byte_reg;
        last_next       = last_reg;
        seq_active_next = seq_active_reg;
        seq_idx_next    = seq_idx_reg;
        if (out_free)
        begin
            if (seq_active_reg)
            begin
                out_valid_next = 1'b1;
                kind_next      = KIND_REPLY;
                byte_next      = reply_at(seq_idx_reg, id_reg, m1_reg, m2_reg);
                last_next      = (seq_idx_reg == REPLY_W'(REPLY_LEN - 1));
                seq_idx_next   = seq_idx_reg + 1'b1;
                if (seq_idx_reg == REPLY_W'(REPLY_LEN - 1))
                begin
                    seq_active_next = 1'b0;
                end
            end
            else if (load_job)
            begin
                out_valid_next = 1'b1;
                unique case (job.kind)
                    JOB_OPEN:
                    begin
                        kind_next = KIND_OPEN;
                        byte_next = 8'd0;
                        last_next = 1'b1;
                    end
                    JOB_RESET:
                    begin
                        kind_next = KIND_RESET;
                        byte_next = 8'd0;
                        last_next = 1'b1;
                    end
                    default:
                    begin
                        kind_next       = KIND_REPLY;
                        byte_next       = reply_at('0, job.id, job.m1, job.m2);
                        last_next       = 1'b0;
                        seq_active_next = 1'b1;
                        seq_idx_next    = REPLY_W'(1);
                    end
                endcase
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            seq_active_reg <= 1'b0;
            seq_idx_reg    <= '0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            seq_active_reg <= seq_active_next;
            seq_idx_reg    <= seq_idx_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
        if (job_ready && load_job)
        begin
            id_reg <= job.id;
            m1_reg <= job.m1;
            m2_reg <= job.m2;
        end
    end

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign reply_byte = byte_reg;
    assign last       = last_reg;

    // A running reply always has a byte waiting in the result register.
    a_seq_has_out: assert property (@(posedge clk) disable iff (!rst_n)
        seq_active_reg |-> out_valid_reg)
        else $error("reply sequence running with empty result register");

    // Commands are single results with a zero byte.
    a_cmd_single: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg != KIND_REPLY) |-> (last_reg && byte_reg == 8'd0))
        else $error("command result malformed");

    // The sequencer never restarts at the header byte.
    a_seq_idx: assert property (@(posedge clk) disable iff (!rst_n)
        seq_active_reg |-> seq_idx_reg != '0)
        else $error("reply index invalid while running");

    // Only the final reply byte carries last.
    a_reply_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == KIND_REPLY && seq_active_reg) |-> !last_reg)
        else $error("last raised before end of reply");

endmodule

>>> bench/command_frame_parser_tb.sv
// Self-checking testbench for command_frame_parser: random bursts of link bytes,
// a byte-level frame predictor and an output checker. Depends on cfp_pkg and the RTL.
`timescale 1ns / 1ps

module command_frame_parser_tb;

    import cfp_pkg::*;

    localparam int unsigned FRAME_LEN = 7;
    localparam int unsigned LIMIT_NS  = 3_000_000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned PHASE_ITEMS   = 55;

    // Receiver stall behavior modes.
    localparam int STALL_NONE  = 0;
    localparam int STALL_LIGHT = 1;
    localparam int STALL_HEAVY = 2;

    typedef enum int {ACT_OPEN, ACT_RESET, ACT_REPLY, ACT_NONE} action_t;
    typedef enum int {FLT_NONE, FLT_TAIL, FLT_SUM, FLT_CMD, FLT_ID} fault_t;

    typedef struct {
        logic [7:0] rx;
        logic [1:0] mode;
    } link_byte_t;

    typedef struct {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
    } frame_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] rx_byte = 8'h00;
    logic [1:0] motor_mode = 2'd0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [1:0] kind;
    logic [7:0] reply_byte;
    logic       last;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] device_id = 8'h00;

    link_byte_t    byte_queue[$];
    frame_result_t frame_results[$];

    // Predictor state: hunt flag, collected frame bytes and the current id.
    logic       in_frame = 1'b0;
    int         frame_fill = 0;
    logic [7:0] frame_data [FRAME_LEN];
    logic [7:0] active_id = DEVICE_ID_RESET;

    int errors = 0;
    int items_queued = 0;
    int bytes_taken = 0;
    int results_seen = 0;
    int frames_ok = 0;
    int opens_seen = 0;
    int resets_seen = 0;
    int replies_seen = 0;
    int id_writes = 0;

    int burst_left = 1;
    int gap_left = 0;
    int stall_mode = STALL_NONE;
    int stall_left = 0;
    link_byte_t req;

    command_frame_parser dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .motor_mode (motor_mode),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .reply_byte (reply_byte),
        .last       (last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .device_id  (device_id)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    task automatic push_result(input logic [1:0] k, input logic [7:0] d, input logic l);
        frame_result_t r;
        r.kind = k;
        r.data = d;
        r.last = l;
        frame_results.push_back(r);
    endtask

    // Works out the results that one accepted byte causes.
    task automatic frame_step(input logic [7:0] rx, input logic [1:0] mode);
        logic [7:0] chk;
        logic [7:0] m1;
        logic [7:0] m2;
        logic [7:0] reply [REPLY_LEN];
        if (!in_frame)
        begin
            if (rx == HDR_BYTE)
            begin
                in_frame = 1'b1;
                frame_fill = 0;
            end
            return;
        end
        frame_data[frame_fill] = rx;
        frame_fill++;
        if (frame_fill < FRAME_LEN)
            return;
        in_frame = 1'b0;
        frame_fill = 0;
        chk = frame_data[1] + frame_data[2] + frame_data[3] + frame_data[4];
        if (frame_data[6] != TAIL_BYTE || frame_data[5] != chk ||
            frame_data[0] != CMD_BYTE || frame_data[1] != active_id)
            return;
        frames_ok++;
        // Open wins over reset, reset wins over the status reply.
        if (frame_data[3] == ONE_BYTE)
        begin
            push_result(KIND_OPEN, 8'h00, 1'b1);
            opens_seen++;
        end
        else if (frame_data[4] == ONE_BYTE)
        begin
            push_result(KIND_RESET, 8'h00, 1'b1);
            resets_seen++;
        end
        else if (frame_data[2] == ONE_BYTE)
        begin
            m1 = (mode == MODE_OPEN) ? 8'd1 : 8'd0;
            m2 = (mode == MODE_RESET) ? 8'd1 : 8'd0;
            reply[0] = HDR_BYTE;
            reply[1] = CMD_BYTE;
            reply[2] = active_id;
            reply[3] = ONE_BYTE;
            reply[4] = m1;
            reply[5] = m2;
            reply[6] = active_id + ONE_BYTE + m1 + m2;
            reply[7] = TAIL_BYTE;
            for (int i = 0; i < REPLY_LEN; i++)
                push_result(KIND_REPLY, reply[i], i == REPLY_LEN - 1);
            replies_seen++;
        end
    endtask

    task automatic push_byte(input logic [7:0] rx, input logic [1:0] mode);
        link_byte_t b;
        b.rx = rx;
        b.mode = mode;
        byte_queue.push_back(b);
        items_queued++;
    endtask

    // Header, six body bytes with random modes, then the closing byte with its mode.
    task automatic push_frame(input logic [7:0] b1, input logic [7:0] b2, input logic [7:0] b3,
                              input logic [7:0] b4, input logic [7:0] b5, input logic [7:0] b6,
                              input logic [7:0] b7, input logic [1:0] mode);
        push_byte(HDR_BYTE, 2'($urandom_range(0, 3)));
        push_byte(b1, 2'($urandom_range(0, 3)));
        push_byte(b2, 2'($urandom_range(0, 3)));
        push_byte(b3, 2'($urandom_range(0, 3)));
        push_byte(b4, 2'($urandom_range(0, 3)));
        push_byte(b5, 2'($urandom_range(0, 3)));
        push_byte(b6, 2'($urandom_range(0, 3)));
        push_byte(b7, mode);
    endtask

    function automatic logic [7:0] not_one();
        logic [7:0] v;
        v = 8'($urandom_range(0, 255));
        return (v == ONE_BYTE) ? 8'h02 : v;
    endfunction

    // Action bytes that are often exactly one, so priority gets exercised.
    function automatic logic [7:0] action_field();
        return ($urandom_range(0, 3) == 0) ? ONE_BYTE : 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] flip_mask();
        return 8'($urandom_range(1, 255));
    endfunction

    task automatic make_frame(input logic [7:0] id, input action_t act, input fault_t flt,
                              input logic [1:0] mode);
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [7:0] b4;
        logic [7:0] b5;
        logic [7:0] b6;
        logic [7:0] b7;
        b1 = CMD_BYTE;
        b2 = id;
        b3 = action_field();
        b4 = action_field();
        b5 = action_field();
        case (act)
            ACT_OPEN:  b4 = ONE_BYTE;
            ACT_RESET:
            begin
                b4 = not_one();
                b5 = ONE_BYTE;
            end
            ACT_REPLY:
            begin
                b3 = ONE_BYTE;
                b4 = not_one();
                b5 = not_one();
            end
            default:
            begin
                b3 = not_one();
                b4 = not_one();
                b5 = not_one();
            end
        endcase
        b6 = b2 + b3 + b4 + b5;
        b7 = TAIL_BYTE;
        // Break one acceptance check; an id fault also breaks the checksum.
        case (flt)
            FLT_TAIL: b7 = b7 ^ flip_mask();
            FLT_SUM:  b6 = b6 ^ flip_mask();
            FLT_CMD:  b1 = b1 ^ flip_mask();
            FLT_ID:   b2 = b2 ^ flip_mask();
            default:  ;
        endcase
        push_frame(b1, b2, b3, b4, b5, b6, b7, mode);
    endtask

    // Random traffic: mostly good frames, some broken frames and line noise.
    task automatic gen_phase(input int count);
        int start;
        int pick;
        int n;
        logic [7:0] v;
        start = items_queued;
        while (items_queued - start < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                make_frame(active_id, action_t'($urandom_range(0, 3)), FLT_NONE,
                           2'($urandom_range(0, 3)));
            else if (pick < 75)
                make_frame(active_id, action_t'($urandom_range(0, 3)),
                           fault_t'($urandom_range(1, 4)), 2'($urandom_range(0, 3)));
            else if (pick < 90)
            begin
                n = $urandom_range(1, 5);
                for (int i = 0; i < n; i++)
                begin
                    v = 8'($urandom_range(0, 255));
                    push_byte((v == HDR_BYTE) ? 8'hAA : v, 2'($urandom_range(0, 3)));
                end
            end
            else
            begin
                // Unfiltered bytes, stray headers included.
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++)
                    push_byte(($urandom_range(0, 3) == 0) ? HDR_BYTE : 8'($urandom_range(0, 255)),
                              2'($urandom_range(0, 3)));
            end
        end
    endtask

    // Waits until the sender has drained and every expected result has come.
    task automatic wait_idle();
        do
            @(posedge clk);
        while (byte_queue.size() != 0 || in_valid || frame_results.size() != 0);
        // A rejected frame can still be in flight without any result.
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_device_id(input logic [7:0] val);
        wait_idle();
        cfg_valid <= 1'b1;
        device_id <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        active_id = val;
        id_writes++;
    endtask

    // Sender: issues requests from the byte queue in bursts with random gaps.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                frame_step(rx_byte, motor_mode);
                bytes_taken++;
            end
            if (in_valid && in_stall)
            begin
                // A stalled request holds its payload.
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (byte_queue.size() > 0)
            begin
                req = byte_queue.pop_front();
                in_valid <= 1'b1;
                rx_byte <= req.rx;
                motor_mode <= req.mode;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                             : $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: checks each accepted result and drives its own stall pattern.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (frame_results.size() == 0)
                    report_mismatch($sformatf("unexpected result kind %0d byte %02h last %0b",
                                              kind, reply_byte, last));
                else
                begin
                    frame_result_t r;
                    r = frame_results.pop_front();
                    if (kind !== r.kind)
                        report_mismatch($sformatf("kind %0d, wanted %0d", kind, r.kind));
                    if (reply_byte !== r.data)
                        report_mismatch($sformatf("reply_byte %02h, wanted %02h",
                                                  reply_byte, r.data));
                    if (last !== r.last)
                        report_mismatch($sformatf("last %0b, wanted %0b", last, r.last));
                end
            end
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(STALL_NONE, STALL_HEAVY);
                stall_left = $urandom_range(8, 64);
            end
            else
            begin
                stall_left--;
            end
            case (stall_mode)
                STALL_NONE:  out_stall <= 1'b0;
                STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                default:     out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Main sequence: reset, directed frames, then random phases under several ids.
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Extreme line bytes while hunting.
        push_byte(8'h00, 2'd0);
        push_byte(8'hFF, 2'd3);
        // Status reply with a header byte inside the frame and an idle mode of 3.
        push_frame(CMD_BYTE, 8'h00, ONE_BYTE, 8'hFF, HDR_BYTE,
                   8'h00 + ONE_BYTE + 8'hFF + HDR_BYTE, TAIL_BYTE, 2'd3);
        // Open command with extreme neighbors.
        push_frame(CMD_BYTE, 8'h00, 8'hFF, ONE_BYTE, 8'h00,
                   8'hFF + ONE_BYTE, TAIL_BYTE, MODE_OPEN);
        // Reset command takes priority over the status reply.
        push_frame(CMD_BYTE, 8'h00, ONE_BYTE, 8'h00, ONE_BYTE,
                   8'h02, TAIL_BYTE, MODE_RESET);

        write_device_id(8'hFF);
        gen_phase(PHASE_ITEMS);
        write_device_id(8'h01);
        gen_phase(PHASE_ITEMS);
        write_device_id(HDR_BYTE);
        gen_phase(PHASE_ITEMS);
        write_device_id(8'($urandom_range(0, 255)));
        gen_phase(PHASE_ITEMS);
        write_device_id(8'h00);
        gen_phase(PHASE_ITEMS);

        wait_idle();
        repeat (20) @(posedge clk);

        $display("Sent %0d bytes over %0d id settings; %0d frames accepted", bytes_taken,
                 id_writes + 1, frames_ok);
        $display("Checked %0d results: %0d open, %0d reset, %0d status replies", results_seen,
                 opens_seen, resets_seen, replies_seen);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Safety net against a hung handshake.
    initial
    begin
        #(LIMIT_NS);
        $display("Timeout with %0d results still outstanding", frame_results.size());
        $display("simulation failed");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/cfp_pkg.sv
hw/rtl/cfp_parser.sv
hw/rtl/cfp_emitter.sv
hw/rtl/command_frame_parser.sv
bench/command_frame_parser_tb.sv
